### rtl/core/microwire_eeprom_master_assert.svh
// Assertion macros used by the top level of the serial EEPROM master RTL.
`ifndef MICROWIRE_EEPROM_MASTER_ASSERT_SVH
`define MICROWIRE_EEPROM_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
`define MWEM_ASSERT_IMPLY(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mwem: implication check failed");
`define MWEM_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mwem: next-cycle check failed");
`else
`define MWEM_ASSERT_IMPLY(label, clock, rst_n, ante, cons)
`define MWEM_ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif
`endif

### rtl/core/mwem_pkg.sv
// Types and constants of the serial EEPROM master.
package mwem_pkg;

	localparam int TICK_W = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WEN   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_WRITE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_WEN,
		SEQ_READ,
		SEQ_WRITE,
		SEQ_CSLOW,
		SEQ_WAIT,
		SEQ_VERIFY
	} seq_state_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HALF_PERIOD  = 3'd0,
		CFG_SAMPLE_DELAY = 3'd1,
		CFG_WRITE_WAIT   = 3'd2,
		CFG_VERIFY_EN    = 3'd3,
		CFG_MAX_TRIES    = 3'd4
	} cfg_index_t;

	localparam logic [15:0]       HALF_PERIOD_RST  = 16'd50;
	localparam logic [15:0]       SAMPLE_DELAY_RST = 16'd100;
	localparam logic [TICK_W-1:0] WRITE_WAIT_RST   = 24'd10000;
	localparam logic              VERIFY_EN_RST    = 1'b1;
	localparam logic [3:0]        MAX_TRIES_RST    = 4'd10;

	typedef struct packed {
		logic [15:0]       half_period_ticks;
		logic [15:0]       sample_delay_ticks;
		logic [TICK_W-1:0] write_wait_ticks;
		logic              verify_enable;
		logic [3:0]        max_tries;
	} cfg_t;

	typedef struct packed {
		action_t     action;
		logic [5:0]  address;
		logic [15:0] write_data;
		logic        data_out_pin;
	} cmd_t;

	typedef struct packed {
		logic        chip_select;
		logic        serial_clock;
		logic        serial_data_in;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_data;
		logic        verify_failed;
		logic        rejected;
	} rsp_t;

endpackage

### rtl/core/microwire_eeprom_master.sv
// Top level of the three-wire serial EEPROM master.

// Commands and ticks enter on the cmd channel, one beat per clock cycle while
// cmd_stall is low; each beat yields exactly one rsp beat carrying the pin
// levels and status after it. A beat is registered in an input stage, the
// sequencer updates its state and forms the result as the beat leaves it, and
// the result is registered in a two-entry output buffer before it appears.
// Sustained rate is one beat per cycle while rsp is not stalled; cmd_stall
// rises only when the input stage holds a beat and the output buffer is full.
// Configuration writes are always accepted and take effect in the next cycle.
module microwire_eeprom_master
	import mwem_pkg::*;
#(
	parameter int ADDR_BITS = 6,
	parameter int DATA_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  cmd_t                   cmd,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output rsp_t                   rsp,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	`include "microwire_eeprom_master_assert.svh"

	cfg_t cfg;
	cmd_t cmd_s1;
	logic cmd_valid_s1;
	logic obuf_full;
	logic s1_move;
	rsp_t seq_result;
	logic rsp_pins_low;

	assign s1_move = cmd_valid_s1 && !obuf_full;
	assign cmd_stall = cmd_valid_s1 && obuf_full;
	assign rsp_pins_low = !rsp.chip_select && !rsp.serial_clock && !rsp.serial_data_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			cmd_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	mwem_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mwem_seq #(
		.ADDR_BITS (ADDR_BITS),
		.DATA_BITS (DATA_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_move),
		.item   (cmd_s1),
		.cfg    (cfg),
		.result (seq_result)
	);

	mwem_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_move),
		.push_data (seq_result),
		.full      (obuf_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`MWEM_ASSERT_IMPLY(a_done_not_busy, clk, arst_n, rsp_valid && rsp.done_res, !rsp.busy_res)
	`MWEM_ASSERT_IMPLY(a_reject_busy, clk, arst_n, rsp_valid && rsp.rejected, rsp.busy_res)
	`MWEM_ASSERT_IMPLY(a_idle_pins_low, clk, arst_n, rsp_valid && !rsp.busy_res, rsp_pins_low)
	`MWEM_ASSERT_NEXT(a_held_beat_kept, clk, arst_n, cmd_valid_s1 && obuf_full, cmd_valid_s1)

endmodule

### rtl/core/mwem_regs.sv
// Configuration register file of the serial EEPROM master.
module mwem_regs
	import mwem_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks  <= HALF_PERIOD_RST;
			cfg_q.sample_delay_ticks <= SAMPLE_DELAY_RST;
			cfg_q.write_wait_ticks   <= WRITE_WAIT_RST;
			cfg_q.verify_enable      <= VERIFY_EN_RST;
			cfg_q.max_tries          <= MAX_TRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_HALF_PERIOD:  cfg_q.half_period_ticks  <= cfg_data[15:0];
				CFG_SAMPLE_DELAY: cfg_q.sample_delay_ticks <= cfg_data[15:0];
				CFG_WRITE_WAIT:   cfg_q.write_wait_ticks   <= cfg_data[TICK_W-1:0];
				CFG_VERIFY_EN:    cfg_q.verify_enable      <= cfg_data[0];
				CFG_MAX_TRIES:    cfg_q.max_tries          <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/mwem_seq.sv
// Pin sequencer: advances the command frame by one item and forms its result.
module mwem_seq
	import mwem_pkg::*;
#(
	parameter int ADDR_BITS = 6,
	parameter int DATA_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  cmd_t item,
	input  cfg_t cfg,
	output rsp_t result
);

	localparam int FRAME_MAX = 6 + ADDR_BITS + DATA_BITS;
	localparam int CW = $clog2(FRAME_MAX + 1);
	localparam int AIW = $clog2(ADDR_BITS);
	localparam int DIW = $clog2(DATA_BITS);

	typedef struct packed {
		logic cs;
		logic di;
		logic rd;
	} bit_info_t;

	seq_state_t st_q, n_st;
	logic [CW-1:0] bit_q, n_bit;
	logic [1:0] phase_q, n_phase;
	logic [TICK_W-1:0] tick_q, n_tick;
	logic [DATA_BITS-1:0] shift_q, n_shift;
	logic [ADDR_BITS-1:0] addr_q, n_addr;
	logic [DATA_BITS-1:0] data_q, n_data;
	logic [3:0] try_q, n_try;
	logic cs_q, n_cs;
	logic clk_q, n_clk;
	logic di_q, n_di;
	logic [DATA_BITS-1:0] rword_q, n_rword;
	logic fail_q, n_fail;
	logic done, rej;

	function automatic bit_info_t bit_info(seq_state_t st, logic [CW-1:0] idx,
			logic [ADDR_BITS-1:0] adr, logic [DATA_BITS-1:0] dat);
		bit_info_t b;
		b.cs = 1'b1;
		b.di = 1'b0;
		b.rd = 1'b0;
		priority if (st == SEQ_WEN) begin
			b.di = (idx == CW'(0)) || (idx == CW'(3)) || (idx == CW'(4));
		end else if (st == SEQ_WRITE) begin
			priority if (idx < CW'(3)) begin
				b.di = (idx != CW'(1));
			end else if (idx < CW'(3 + ADDR_BITS)) begin
				b.di = adr[AIW'(CW'(ADDR_BITS + 2) - idx)];
			end else if (idx < CW'(3 + ADDR_BITS + DATA_BITS)) begin
				b.di = dat[DIW'(CW'(ADDR_BITS + DATA_BITS + 2) - idx)];
			end else begin
			end
		end else begin
			priority if (idx < CW'(2)) begin
				b.cs = 1'b0;
			end else if ((idx == CW'(3)) || (idx == CW'(4))) begin
				b.di = 1'b1;
			end else if ((idx >= CW'(6)) && (idx < CW'(6 + ADDR_BITS))) begin
				b.di = adr[AIW'(CW'(ADDR_BITS + 5) - idx)];
			end else if (idx >= CW'(6 + ADDR_BITS)) begin
				b.rd = 1'b1;
			end else begin
			end
		end
		return b;
	endfunction

	always_comb begin
		bit_info_t cur;
		bit_info_t nxt;
		logic [CW-1:0] bit_inc;
		logic [CW-1:0] frame_len;
		logic [TICK_W-1:0] tick_inc;
		logic [TICK_W-1:0] len;
		logic [TICK_W-1:0] hp1;
		logic [TICK_W-1:0] ww1;
		logic [3:0] mt1;
		logic [3:0] try_inc;
		logic [DATA_BITS-1:0] shift_in;

		n_st = st_q;
		n_bit = bit_q;
		n_phase = phase_q;
		n_tick = tick_q;
		n_shift = shift_q;
		n_addr = addr_q;
		n_data = data_q;
		n_try = try_q;
		n_cs = cs_q;
		n_clk = clk_q;
		n_di = di_q;
		n_rword = rword_q;
		n_fail = fail_q;
		done = 1'b0;
		rej = 1'b0;

		cur = bit_info(st_q, bit_q, addr_q, data_q);
		bit_inc = bit_q + CW'(1);
		nxt = bit_info(st_q, bit_inc, addr_q, data_q);
		tick_inc = tick_q + TICK_W'(1);
		hp1 = (cfg.half_period_ticks == 16'd0) ? TICK_W'(1) : TICK_W'(cfg.half_period_ticks);
		ww1 = (cfg.write_wait_ticks == '0) ? TICK_W'(1) : cfg.write_wait_ticks;
		mt1 = (cfg.max_tries == 4'd0) ? 4'd1 : cfg.max_tries;
		try_inc = try_q + 4'd1;
		shift_in = {shift_q[DATA_BITS-2:0], item.data_out_pin};

		priority if (st_q == SEQ_WEN) begin
			frame_len = CW'(3 + ADDR_BITS);
		end else if (st_q == SEQ_WRITE) begin
			frame_len = CW'(3 + ADDR_BITS + DATA_BITS);
		end else begin
			frame_len = CW'(6 + ADDR_BITS + DATA_BITS);
		end

		priority if (st_q == SEQ_CSLOW) begin
			len = hp1;
		end else if (st_q == SEQ_WAIT) begin
			len = ww1;
		end else if (phase_q == 2'd3) begin
			len = TICK_W'(cfg.sample_delay_ticks);
		end else begin
			len = hp1;
		end

		if (fire) begin
			if (item.action != ACT_TICK) begin
				if (st_q != SEQ_IDLE) begin
					rej = 1'b1;
				end else begin
					n_addr = ADDR_BITS'(item.address);
					n_data = item.write_data[DATA_BITS-1:0];
					n_try = 4'd0;
					n_fail = 1'b0;
					priority if (item.action == ACT_WEN) begin
						n_st = SEQ_WEN;
					end else if (item.action == ACT_READ) begin
						n_st = SEQ_READ;
					end else begin
						n_st = SEQ_WRITE;
					end
					n_bit = '0;
					n_shift = '0;
					n_phase = 2'd0;
					n_tick = '0;
					// The first two bits of a read frame have chip select and data in low; other frames start with both at one.
					n_cs = (item.action != ACT_READ);
					n_clk = 1'b0;
					n_di = (item.action != ACT_READ);
				end
			end else if (st_q != SEQ_IDLE) begin
				if (tick_inc < len) begin
					n_tick = tick_inc;
				end else begin
					n_tick = '0;
					priority if (st_q == SEQ_CSLOW) begin
						n_st = SEQ_WAIT;
						n_cs = 1'b1;
						n_clk = 1'b0;
						n_di = 1'b0;
					end else if (st_q == SEQ_WAIT) begin
						n_phase = 2'd0;
						n_cs = 1'b0;
						n_clk = 1'b0;
						n_di = 1'b0;
						if (cfg.verify_enable) begin
							n_st = SEQ_VERIFY;
							n_bit = '0;
							n_shift = '0;
						end else begin
							n_st = SEQ_IDLE;
							done = 1'b1;
						end
					end else if (phase_q == 2'd0) begin
						n_phase = 2'd1;
						n_clk = 1'b1;
					end else if (phase_q == 2'd1) begin
						n_phase = 2'd2;
						n_clk = 1'b0;
					end else if ((phase_q == 2'd2) && cur.rd &&
							(cfg.sample_delay_ticks != 16'd0)) begin
						n_phase = 2'd3;
					end else begin
						if (cur.rd) begin
							n_shift = shift_in;
						end
						n_bit = bit_inc;
						if (bit_inc < frame_len) begin
							n_phase = 2'd0;
							n_cs = nxt.cs;
							n_clk = 1'b0;
							n_di = nxt.di;
						end else begin
							n_cs = 1'b0;
							n_clk = 1'b0;
							n_di = 1'b0;
							priority if (st_q == SEQ_WRITE) begin
								n_st = SEQ_CSLOW;
							end else if (st_q == SEQ_VERIFY) begin
								n_rword = n_shift;
								priority if (n_shift == data_q) begin
									n_st = SEQ_IDLE;
									n_phase = 2'd0;
									done = 1'b1;
								end else if (try_inc >= mt1) begin
									n_try = try_inc;
									n_fail = 1'b1;
									n_st = SEQ_IDLE;
									n_phase = 2'd0;
									done = 1'b1;
								end else begin
									n_try = try_inc;
									n_st = SEQ_WRITE;
									n_bit = '0;
									n_shift = '0;
									n_phase = 2'd0;
									n_cs = 1'b1;
									n_di = 1'b1;
								end
							end else begin
								if (st_q == SEQ_READ) begin
									n_rword = n_shift;
								end
								n_st = SEQ_IDLE;
								n_phase = 2'd0;
								done = 1'b1;
							end
						end
					end
				end
			end
		end
	end

	always_comb begin
		result.chip_select = n_cs;
		result.serial_clock = n_clk;
		result.serial_data_in = n_di;
		result.busy_res = (n_st != SEQ_IDLE);
		result.done_res = done;
		result.read_data = 16'(n_rword);
		result.verify_failed = n_fail;
		result.rejected = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SEQ_IDLE;
			bit_q <= '0;
			phase_q <= 2'd0;
			tick_q <= '0;
			try_q <= 4'd0;
			cs_q <= 1'b0;
			clk_q <= 1'b0;
			di_q <= 1'b0;
			rword_q <= '0;
			fail_q <= 1'b0;
		end else if (fire) begin
			st_q <= n_st;
			bit_q <= n_bit;
			phase_q <= n_phase;
			tick_q <= n_tick;
			try_q <= n_try;
			cs_q <= n_cs;
			clk_q <= n_clk;
			di_q <= n_di;
			rword_q <= n_rword;
			fail_q <= n_fail;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			shift_q <= n_shift;
			addr_q <= n_addr;
			data_q <= n_data;
		end
	end

endmodule

### rtl/core/mwem_obuf.sv
// Two-entry result buffer between the sequencer and the result channel.
module mwem_obuf
	import mwem_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsp_t push_data,
	output logic full,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	rsp_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	assign rsp_valid = (count_q != 2'd0);
	assign full = (count_q == 2'd2);
	assign pop = rsp_valid && !rsp_stall;
	assign rsp = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### dv/microwire_eeprom_master_tb.sv
// Self-checking testbench for the serial EEPROM master: pin sequences, read, write, verify.
`timescale 1ns / 100ps

module microwire_eeprom_master_tb
	import mwem_pkg::*;
();

	localparam int ABITS = 6;
	localparam int DBITS = 16;
	localparam int RANDOM_BEATS = 400;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	microwire_eeprom_master u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Configuration as the sequencer sees it.
	logic [15:0] cfg_half = 16'd50;
	logic [15:0] cfg_sdly = 16'd100;
	logic [23:0] cfg_wait = 24'd10000;
	logic cfg_ven = 1'b1;
	logic [3:0] cfg_tries = 4'd10;

	// Sequencer state.
	seq_state_t seq = SEQ_IDLE;
	int unsigned bit_idx = 0;
	int unsigned ph = 0;
	int unsigned tick_cnt = 0;
	logic [15:0] shifter = '0;
	logic [15:0] word_rd = '0;
	logic [5:0] lat_addr = '0;
	logic [15:0] lat_data = '0;
	logic [3:0] tries_used = '0;
	logic pin_cs = 1'b0;
	logic pin_clk = 1'b0;
	logic pin_di = 1'b0;
	logic fail_flag = 1'b0;
	logic seq_done;

	rsp_t pin_status_q[$];

	int unsigned n_errors = 0;
	int unsigned n_checked = 0;
	int unsigned n_sequences = 0;
	int unsigned n_rejected = 0;
	int unsigned n_vfail = 0;
	int unsigned n_phases = 0;
	int unsigned n_beats = 0;
	int unsigned flip_pct = 0;
	bit cmd_quiet = 1'b0;
	bit rsp_quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned at_least_one(input int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic int unsigned frame_bits();
		case (seq)
			SEQ_WEN: return 3 + ABITS;
			SEQ_WRITE: return 3 + ABITS + DBITS;
			default: return 6 + ABITS + DBITS;
		endcase
	endfunction

	function automatic void bit_levels(input int unsigned idx, output logic cs, output logic di,
		output logic rd);
		cs = 1'b1;
		di = 1'b0;
		rd = 1'b0;
		case (seq)
			SEQ_WEN: di = (idx == 0 || idx == 3 || idx == 4);
			SEQ_WRITE: begin
				if (idx < 3)
					di = (idx != 1);
				else if (idx < 3 + ABITS)
					di = lat_addr[ABITS - 1 - (idx - 3)];
				else
					di = lat_data[DBITS - 1 - (idx - 3 - ABITS)];
			end
			default: begin
				if (idx < 2)
					cs = 1'b0;
				else if (idx == 3 || idx == 4)
					di = 1'b1;
				else if (idx >= 6 && idx < 6 + ABITS)
					di = lat_addr[ABITS - 1 - (idx - 6)];
				else if (idx >= 6 + ABITS)
					rd = 1'b1;
			end
		endcase
	endfunction

	function automatic void load_bit();
		logic cs, di, rd;
		bit_levels(bit_idx, cs, di, rd);
		ph = 0;
		tick_cnt = 0;
		pin_cs = cs;
		pin_clk = 1'b0;
		pin_di = di;
	endfunction

	function automatic void start_frame(input seq_state_t s);
		seq = s;
		bit_idx = 0;
		shifter = '0;
		load_bit();
	endfunction

	function automatic void finish_seq();
		seq = SEQ_IDLE;
		{pin_cs, pin_clk, pin_di} = 3'b000;
		ph = 0;
		tick_cnt = 0;
		seq_done = 1'b1;
	endfunction

	function automatic void frame_end();
		case (seq)
			SEQ_READ: begin
				word_rd = shifter;
				finish_seq();
			end
			SEQ_WRITE: begin
				seq = SEQ_CSLOW;
				{pin_cs, pin_clk, pin_di} = 3'b000;
				tick_cnt = 0;
			end
			SEQ_VERIFY: begin
				word_rd = shifter;
				if (word_rd == lat_data) begin
					finish_seq();
				end else begin
					tries_used = tries_used + 4'd1;
					if (tries_used >= at_least_one(cfg_tries)) begin
						fail_flag = 1'b1;
						finish_seq();
					end else begin
						start_frame(SEQ_WRITE);
					end
				end
			end
			default: finish_seq();
		endcase
	endfunction

	function automatic void tick_sequencer(input logic dout);
		int unsigned len;
		logic cs, di, rd;
		tick_cnt++;
		if (seq == SEQ_CSLOW || seq == SEQ_WAIT) begin
			len = (seq == SEQ_CSLOW) ? at_least_one(cfg_half) : at_least_one(cfg_wait);
			if (tick_cnt < len)
				return;
			tick_cnt = 0;
			if (seq == SEQ_CSLOW) begin
				seq = SEQ_WAIT;
				{pin_cs, pin_clk, pin_di} = 3'b100;
			end else if (cfg_ven) begin
				start_frame(SEQ_VERIFY);
			end else begin
				finish_seq();
			end
			return;
		end
		len = (ph == 3) ? cfg_sdly : at_least_one(cfg_half);
		if (tick_cnt < len)
			return;
		tick_cnt = 0;
		if (ph == 0) begin
			ph = 1;
			pin_clk = 1'b1;
			return;
		end
		if (ph == 1) begin
			ph = 2;
			pin_clk = 1'b0;
			return;
		end
		bit_levels(bit_idx, cs, di, rd);
		if (ph == 2 && rd && cfg_sdly != 0) begin
			ph = 3;
			return;
		end
		if (rd)
			shifter = {shifter[14:0], dout};
		bit_idx++;
		if (bit_idx < frame_bits())
			load_bit();
		else
			frame_end();
	endfunction

	function automatic rsp_t sequence_beat(input cmd_t b);
		rsp_t r;
		logic rej;
		seq_done = 1'b0;
		rej = 1'b0;
		if (b.action != ACT_TICK) begin
			if (seq != SEQ_IDLE) begin
				rej = 1'b1;
			end else begin
				lat_addr = b.address;
				lat_data = b.write_data;
				tries_used = '0;
				fail_flag = 1'b0;
				case (b.action)
					ACT_WEN: start_frame(SEQ_WEN);
					ACT_READ: start_frame(SEQ_READ);
					default: start_frame(SEQ_WRITE);
				endcase
			end
		end else if (seq != SEQ_IDLE) begin
			tick_sequencer(b.data_out_pin);
		end
		r.chip_select = pin_cs;
		r.serial_clock = pin_clk;
		r.serial_data_in = pin_di;
		r.busy_res = (seq != SEQ_IDLE);
		r.done_res = seq_done;
		r.read_data = word_rd;
		r.verify_failed = fail_flag;
		r.rejected = rej;
		if (seq_done)
			n_sequences++;
		if (rej)
			n_rejected++;
		if (seq_done && fail_flag)
			n_vfail++;
		return r;
	endfunction

	// Data-out level of the part: the written word during read-back, with optional faults.
	function automatic logic eeprom_dout();
		if (seq == SEQ_VERIFY && bit_idx >= 6 + ABITS)
			return lat_data[DBITS + 5 + ABITS - bit_idx] ^ ($urandom_range(99) < flip_pct);
		return 1'($urandom_range(1));
	endfunction

	task automatic report_mismatch(input string msg);
		if (n_errors < 100)
			$display("[%0t] mismatch: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic send_beat(input cmd_t beat);
		if (!cmd_quiet) begin
			while ($urandom_range(99) < 11) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd <= beat;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pin_status_q.push_back(sequence_beat(beat));
	endtask

	task automatic send_tick();
		cmd_t beat;
		beat.action = ACT_TICK;
		beat.address = 6'($urandom);
		beat.write_data = 16'($urandom);
		beat.data_out_pin = eeprom_dout();
		send_beat(beat);
	endtask

	task automatic send_command(input action_t act, input logic [5:0] addr,
		input logic [15:0] data);
		cmd_t beat;
		beat.action = act;
		beat.address = addr;
		beat.write_data = data;
		beat.data_out_pin = 1'($urandom_range(1));
		send_beat(beat);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (pin_status_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// One command and the ticks that carry it to the end, with some rejected commands mixed in.
	task automatic run_command(input action_t act, input logic [5:0] addr,
		input logic [15:0] data, input int unsigned reject_pct);
		send_command(act, addr, data);
		n_beats++;
		while (seq != SEQ_IDLE) begin
			if ($urandom_range(999) < reject_pct * 10) begin
				send_command(action_t'($urandom_range(1, 3)), 6'($urandom), 16'($urandom));
			end else begin
				if ($urandom_range(999) < 2)
					drain();
				send_tick();
				n_beats++;
			end
		end
	endtask

	task automatic program_config(input logic [23:0] half, input logic [23:0] sdly,
		input logic [23:0] wwait, input logic [23:0] ven, input logic [23:0] tries);
		logic [23:0] vals[5];
		cfg_index_t idx;
		drain();
		vals = '{half, sdly, wwait, ven, tries};
		idx = CFG_HALF_PERIOD;
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx)
				CFG_HALF_PERIOD: cfg_half = vals[i][15:0];
				CFG_SAMPLE_DELAY: cfg_sdly = vals[i][15:0];
				CFG_WRITE_WAIT: cfg_wait = vals[i][23:0];
				CFG_VERIFY_EN: cfg_ven = vals[i][0];
				default: cfg_tries = vals[i][3:0];
			endcase
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
		n_phases++;
	endtask

	task automatic test_reset_values();
		repeat (3) send_tick();
	endtask

	task automatic test_write_verify();
		program_config(24'hFF0000, 24'h000000, 24'h000000, 24'h000001, 24'hFFFFF0);
		flip_pct = 100;
		run_command(ACT_WRITE, 6'h15, 16'hA5C3, 0);
		repeat (3) send_tick();
		flip_pct = 0;
		run_command(ACT_WRITE, 6'h3F, 16'hFFFF, 0);
		run_command(ACT_WRITE, 6'h00, 16'h0000, 0);
		program_config(24'hFF0001, 24'h000001, 24'h000002, 24'h000001, 24'h000003);
		flip_pct = 100;
		run_command(ACT_WRITE, 6'h2A, 16'h5555, 0);
		flip_pct = 0;
		program_config(24'h000002, 24'h000002, 24'h000003, 24'hFFFFFE, 24'h000003);
		run_command(ACT_WRITE, 6'h3F, 16'h8001, 0);
	endtask

	task automatic test_read_frames();
		program_config(24'h000002, 24'h000000, 24'h000001, 24'h000001, 24'h000002);
		run_command(ACT_READ, 6'h00, 16'h0000, 0);
		run_command(ACT_READ, 6'h3F, 16'h0000, 0);
		program_config(24'h000001, 24'h000003, 24'h000001, 24'h000001, 24'h000002);
		run_command(ACT_READ, 6'h21, 16'h1234, 0);
	endtask

	task automatic test_busy_reject();
		send_command(ACT_READ, 6'h12, 16'h0000);
		send_command(ACT_WEN, 6'h3F, 16'hFFFF);
		send_command(ACT_READ, 6'h00, 16'h0000);
		send_command(ACT_WRITE, 6'h2D, 16'hBEEF);
		repeat (20) send_tick();
		drain();
		while (seq != SEQ_IDLE)
			send_tick();
		send_tick();
	endtask

	task automatic test_register_extremes();
		program_config(24'h000001, 24'h00FFFF, 24'hFFFFFF, 24'h000001, 24'h00000F);
		run_command(ACT_WEN, 6'h3F, 16'h0000, 0);
		program_config(24'h000001, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000001);
		run_command(ACT_READ, 6'h0F, 16'h0000, 0);
		program_config(24'h00FFFF, 24'h000000, 24'h000001, 24'h000001, 24'h000001);
		repeat (4) send_tick();
	endtask

	task automatic test_random_traffic();
		int unsigned start;
		int unsigned phase_no;
		logic [5:0] addr;
		logic [15:0] data;
		start = n_beats;
		phase_no = 0;
		while (n_beats - start < RANDOM_BEATS) begin
			program_config(($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(1, 3)),
				24'($urandom_range(0, 3)), 24'($urandom_range(0, 6)),
				24'($urandom_range(1)), 24'($urandom_range(0, 4)));
			cmd_quiet = (phase_no == 0);
			rsp_quiet = (phase_no == 0);
			repeat (4) begin
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(1, 3)) send_tick();
				case ($urandom_range(3))
					0: flip_pct = 2;
					1: flip_pct = 10;
					default: flip_pct = 0;
				endcase
				addr = 6'($urandom);
				data = 16'($urandom);
				if ($urandom_range(7) == 0)
					addr = $urandom_range(1) ? 6'h3F : 6'h00;
				if ($urandom_range(7) == 0)
					data = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				run_command(action_t'($urandom_range(1, 3)), addr, data, 2);
			end
			phase_no++;
		end
		cmd_quiet = 1'b0;
		rsp_quiet = 1'b0;
		flip_pct = 0;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pin_status_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pin_status_q.pop_front();
				if (rsp.chip_select !== want.chip_select)
					report_mismatch($sformatf("result %0d chip_select %b, expected %b",
						n_checked, rsp.chip_select, want.chip_select));
				if (rsp.serial_clock !== want.serial_clock)
					report_mismatch($sformatf("result %0d serial_clock %b, expected %b",
						n_checked, rsp.serial_clock, want.serial_clock));
				if (rsp.serial_data_in !== want.serial_data_in)
					report_mismatch($sformatf("result %0d serial_data_in %b, expected %b",
						n_checked, rsp.serial_data_in, want.serial_data_in));
				if (rsp.busy_res !== want.busy_res)
					report_mismatch($sformatf("result %0d busy_res %b, expected %b",
						n_checked, rsp.busy_res, want.busy_res));
				if (rsp.done_res !== want.done_res)
					report_mismatch($sformatf("result %0d done_res %b, expected %b",
						n_checked, rsp.done_res, want.done_res));
				if (rsp.read_data !== want.read_data)
					report_mismatch($sformatf("result %0d read_data %h, expected %h",
						n_checked, rsp.read_data, want.read_data));
				if (rsp.verify_failed !== want.verify_failed)
					report_mismatch($sformatf("result %0d verify_failed %b, expected %b",
						n_checked, rsp.verify_failed, want.verify_failed));
				if (rsp.rejected !== want.rejected)
					report_mismatch($sformatf("result %0d rejected %b, expected %b",
						n_checked, rsp.rejected, want.rejected));
			end
			n_checked++;
		end
		rsp_stall <= !rsp_quiet && ($urandom_range(99) < 11);
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
		$display("** microwire_eeprom_master: FAILED **");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_write_verify();
		test_read_frames();
		test_busy_reject();
		test_register_extremes();
		test_random_traffic();
		drain();
		repeat (10) @(posedge clk);
		if (pin_status_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pin_status_q.size()));
		$display("Run covered %0d results over %0d register settings: %0d sequences done,",
			n_checked, n_phases, n_sequences);
		$display("%0d commands rejected while busy, %0d writes that failed read-back.",
			n_rejected, n_vfail);
		if (n_errors == 0)
			$display("** microwire_eeprom_master: PASSED **");
		else
			$display("** microwire_eeprom_master: FAILED **");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/mwem_pkg.sv
rtl/core/mwem_regs.sv
rtl/core/mwem_seq.sv
rtl/core/mwem_obuf.sv
rtl/core/microwire_eeprom_master.sv
dv/microwire_eeprom_master_tb.sv
